// ===== rtl/core/wdt_pkg.sv =====
package wdt_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int DATA_WIDTH = 32;
   localparam int CMD_WIDTH  = 2;
   localparam int SEL_WIDTH  = 3;
   localparam int CTRL_WIDTH = 6;
   localparam int SS_WIDTH   = 16;
   localparam int PS_WIDTH   = 8;
   localparam int PTV_WIDTH  = 3;
   localparam int PEND_WIDTH = 5;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd2;

   // register selects
   localparam logic [SEL_WIDTH-1:0] SEL_CONTROL   = 3'd0;
   localparam logic [SEL_WIDTH-1:0] SEL_COUNTER   = 3'd1;
   localparam logic [SEL_WIDTH-1:0] SEL_LOAD      = 3'd2;
   localparam logic [SEL_WIDTH-1:0] SEL_TRIGGER   = 3'd3;
   localparam logic [SEL_WIDTH-1:0] SEL_STARTSTOP = 3'd4;
   localparam logic [SEL_WIDTH-1:0] SEL_PENDING   = 3'd5;

   // start/stop key sequences
   localparam logic [SS_WIDTH-1:0] KEY_START_1 = 16'hBBBB;
   localparam logic [SS_WIDTH-1:0] KEY_START_2 = 16'h4444;
   localparam logic [SS_WIDTH-1:0] KEY_STOP_1  = 16'hAAAA;
   localparam logic [SS_WIDTH-1:0] KEY_STOP_2  = 16'h5555;

   localparam logic [CTRL_WIDTH-1:0] CTRL_WRITE_MASK = 6'h3C;
   localparam int CTRL_PRE_BIT = 5;
   localparam int CTRL_PTV_LSB = 2;

   // pending status bit positions
   localparam int PEND_CONTROL   = 0;
   localparam int PEND_COUNTER   = 1;
   localparam int PEND_LOAD      = 2;
   localparam int PEND_TRIGGER   = 3;
   localparam int PEND_STARTSTOP = 4;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [SEL_WIDTH-1:0]  reg_select;
      logic [DATA_WIDTH-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  reset_request;
   } result_type;

endpackage

// ===== rtl/core/watchdog_timer_registers.sv =====
// Channel   Ports                                          Direction
// req       req_valid req_stall req_command                in (stall out)
//           req_reg_select req_write_data
// rsp       rsp_valid rsp_stall rsp_read_data              out (stall in)
//           rsp_reset_request
//
// One word per cycle sustained while rsp is not stalled; a taken word passes the input
// register, then the register file update and the result register, before rsp offers it.
// Synchronous active-high reset zeroes both valid flags and every core register and stops the watchdog.
// A stall on rsp holds the result register and backs up into req_stall
// only when both the input and the result register are full.
module watchdog_timer_registers #(
   parameter int COUNT_WIDTH = wdt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wdt_pkg::CMD_WIDTH-1:0]       req_command,
   input  logic [wdt_pkg::SEL_WIDTH-1:0]       req_reg_select,
   input  logic [wdt_pkg::DATA_WIDTH-1:0]      req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wdt_pkg::DATA_WIDTH-1:0]      rsp_read_data,
   output logic                                rsp_reset_request
);

   wdt_pkg::item_type   item_ff, item_in;
   logic                item_valid_ff, item_valid_in;
   wdt_pkg::result_type result;
   wdt_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                move;
   logic                take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   wdt_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (move),
      .item   (item_ff),
      .result (result)
   );

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (take) begin
         item_in.command    = req_command;
         item_in.reg_select = req_reg_select;
         item_in.write_data = req_write_data;
         item_valid_in      = 1'b1;
      end else if (move) begin
         item_valid_in = 1'b0;
      end
      if (move) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         // drop the delivered word
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_reset_request = rsp_ff.reset_request;

endmodule

// ===== rtl/core/wdt_core.sv =====
module wdt_core #(
   parameter int COUNT_WIDTH = wdt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  wdt_pkg::item_type   item,
   output wdt_pkg::result_type result
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [wdt_pkg::CTRL_WIDTH-1:0] control_ff, control_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic [COUNT_WIDTH-1:0]         load_ff, load_in;
   logic [wdt_pkg::DATA_WIDTH-1:0] trigger_ff, trigger_in;
   logic [wdt_pkg::SS_WIDTH-1:0]   ss_ff, ss_in;
   logic                           running_ff, running_in;
   logic [wdt_pkg::PS_WIDTH-1:0]   ps_ff, ps_in;
   logic [wdt_pkg::PEND_WIDTH-1:0] pend_ff, pend_in;

   logic [wdt_pkg::SS_WIDTH-1:0]   ss_word;
   logic [wdt_pkg::PS_WIDTH-1:0]   ps_inc;
   logic [wdt_pkg::PS_WIDTH-1:0]   ps_limit;
   logic [wdt_pkg::PTV_WIDTH-1:0]  ptv;
   logic                           advance;

   assign ss_word  = item.write_data[wdt_pkg::SS_WIDTH-1:0];
   assign ptv      = control_ff[wdt_pkg::CTRL_PTV_LSB +: wdt_pkg::PTV_WIDTH];
   assign ps_inc   = ps_ff + wdt_pkg::PS_WIDTH'(1);
   assign ps_limit = wdt_pkg::PS_WIDTH'(1) << ptv;

   always_comb begin
      control_in           = control_ff;
      count_in             = count_ff;
      load_in              = load_ff;
      trigger_in           = trigger_ff;
      ss_in                = ss_ff;
      running_in           = running_ff;
      ps_in                = ps_ff;
      pend_in              = pend_ff;
      advance              = 1'b0;
      result.read_data     = '0;
      result.reset_request = 1'b0;
      if (go) begin
         case (item.command)
            wdt_pkg::CMD_READ: begin
               case (item.reg_select)
                  wdt_pkg::SEL_CONTROL:
                     result.read_data = wdt_pkg::DATA_WIDTH'(control_ff);
                  wdt_pkg::SEL_COUNTER:
                     result.read_data = wdt_pkg::DATA_WIDTH'(count_ff);
                  wdt_pkg::SEL_LOAD:
                     result.read_data = wdt_pkg::DATA_WIDTH'(load_ff);
                  wdt_pkg::SEL_TRIGGER:
                     result.read_data = trigger_ff;
                  wdt_pkg::SEL_STARTSTOP:
                     result.read_data = wdt_pkg::DATA_WIDTH'(ss_ff);
                  wdt_pkg::SEL_PENDING:
                     result.read_data = wdt_pkg::DATA_WIDTH'(pend_ff);
                  default:
                     result.read_data = '0;
               endcase
            end
            wdt_pkg::CMD_WRITE: begin
               case (item.reg_select)
                  wdt_pkg::SEL_CONTROL: begin
                     control_in = item.write_data[wdt_pkg::CTRL_WIDTH-1:0]
                                  & wdt_pkg::CTRL_WRITE_MASK;
                     pend_in[wdt_pkg::PEND_CONTROL] = 1'b1;
                  end
                  wdt_pkg::SEL_COUNTER: begin
                     count_in = item.write_data[COUNT_WIDTH-1:0];
                     pend_in[wdt_pkg::PEND_COUNTER] = 1'b1;
                  end
                  wdt_pkg::SEL_LOAD: begin
                     load_in = item.write_data[COUNT_WIDTH-1:0];
                     pend_in[wdt_pkg::PEND_LOAD] = 1'b1;
                  end
                  wdt_pkg::SEL_TRIGGER: begin
                     // reload only on a changed trigger word
                     if (item.write_data != trigger_ff) begin
                        count_in = load_ff;
                        ps_in    = '0;
                     end
                     trigger_in = item.write_data;
                     pend_in[wdt_pkg::PEND_TRIGGER] = 1'b1;
                  end
                  wdt_pkg::SEL_STARTSTOP: begin
                     if (ss_ff == wdt_pkg::KEY_START_1 && ss_word == wdt_pkg::KEY_START_2)
                        running_in = 1'b1;
                     else if (ss_ff == wdt_pkg::KEY_STOP_1 &&
                              ss_word == wdt_pkg::KEY_STOP_2)
                        running_in = 1'b0;
                     ss_in = ss_word;
                     pend_in[wdt_pkg::PEND_STARTSTOP] = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            wdt_pkg::CMD_TICK: begin
               pend_in = '0;
               if (running_ff) begin
                  if (control_ff[wdt_pkg::CTRL_PRE_BIT]) begin
                     if (ps_inc >= ps_limit) begin
                        ps_in   = '0;
                        advance = 1'b1;
                     end else begin
                        ps_in = ps_inc;
                     end
                  end else begin
                     ps_in   = '0;
                     advance = 1'b1;
                  end
                  if (advance) begin
                     if (count_ff == COUNT_MAX) begin
                        count_in             = load_ff;
                        result.reset_request = 1'b1;
                     end else begin
                        count_in = count_ff + COUNT_WIDTH'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         count_ff   <= '0;
         load_ff    <= '0;
         trigger_ff <= '0;
         ss_ff      <= '0;
         running_ff <= 1'b0;
         ps_ff      <= '0;
         pend_ff    <= '0;
      end else begin
         control_ff <= control_in;
         count_ff   <= count_in;
         load_ff    <= load_in;
         trigger_ff <= trigger_in;
         ss_ff      <= ss_in;
         running_ff <= running_in;
         ps_ff      <= ps_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

// ===== dv/watchdog_timer_registers_tb.sv =====
module watchdog_timer_registers_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wdt_pkg::*;

   localparam int CW        = COUNT_WIDTH_DEFAULT;
   localparam int N_RANDOM  = 750;
   localparam int LIMIT     = 400000;
   localparam int TAIL      = 10;
   localparam int N_DIR     = 27;
   localparam int HOLD_LEN  = 300;
   localparam int HOLD_AT   = 400;

   // codes the package leaves unnamed
   localparam logic [CMD_WIDTH-1:0] CMD_NONE    = 2'd3;
   localparam logic [SEL_WIDTH-1:0] SEL_SPARE_6 = 3'd6;
   localparam logic [SEL_WIDTH-1:0] SEL_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [SEL_WIDTH-1:0]  sel;
      logic [DATA_WIDTH-1:0] data;
      bit                    typed;
      logic [DATA_WIDTH-1:0] rd;
      logic                  rr;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_WIDTH-1:0]  req_command = CMD_READ;
   logic [SEL_WIDTH-1:0]  req_reg_select = SEL_CONTROL;
   logic [DATA_WIDTH-1:0] req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_read_data;
   logic                  rsp_reset_request;

   // predictor state
   logic [CTRL_WIDTH-1:0] m_ctrl;
   logic [CW-1:0]         m_count;
   logic [CW-1:0]         m_load;
   logic [DATA_WIDTH-1:0] m_trig;
   logic [SS_WIDTH-1:0]   m_ss;
   bit                    m_run;
   logic [PS_WIDTH-1:0]   m_ps;
   logic [PEND_WIDTH-1:0] m_pend;

   item_type   stim[$];
   bit         stim_typed[$];
   result_type stim_rsp[$];
   result_type rsp_due_q[$];
   int         n_fail = 0;
   int         n_rsp = 0;
   int         n_cycles = 0;

   dir_row_type dir_tab [N_DIR] = '{
      '{CMD_READ,  SEL_CONTROL,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{CMD_READ,  SEL_COUNTER,   32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      '{CMD_READ,  SEL_PENDING,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{CMD_READ,  SEL_SPARE_7,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{CMD_NONE,  SEL_SPARE_7,   32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_LOAD,      32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_COUNTER,   32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
      '{CMD_READ,  SEL_PENDING,   32'h0000_0000, 1'b1,
        (32'd1 << PEND_COUNTER) | (32'd1 << PEND_LOAD), 1'b0},
      '{CMD_WRITE, SEL_STARTSTOP, {16'hFFFF, KEY_START_1}, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_STARTSTOP, {16'h0000, KEY_START_2}, 1'b0, 32'h0, 1'b0},
      '{CMD_TICK,  SEL_CONTROL,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{CMD_TICK,  SEL_CONTROL,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{CMD_READ,  SEL_COUNTER,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_WRITE, SEL_TRIGGER,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{CMD_READ,  SEL_PENDING,   32'h0000_0000, 1'b1, 32'd1 << PEND_TRIGGER, 1'b0},
      '{CMD_WRITE, SEL_TRIGGER,   32'h0000_1234, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_CONTROL,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_READ,  SEL_CONTROL,   32'h0000_0000, 1'b1,
        {{(DATA_WIDTH-CTRL_WIDTH){1'b0}}, CTRL_WRITE_MASK}, 1'b0},
      '{CMD_WRITE, SEL_PENDING,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_SPARE_6,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_TICK,  SEL_CONTROL,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_CONTROL,   32'h0000_0020, 1'b0, 32'h0, 1'b0},
      '{CMD_TICK,  SEL_CONTROL,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_STARTSTOP, {16'h0000, KEY_STOP_1}, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, SEL_STARTSTOP, {16'h0000, KEY_STOP_2}, 1'b0, 32'h0, 1'b0},
      '{CMD_TICK,  SEL_CONTROL,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{CMD_READ,  SEL_STARTSTOP, 32'h0000_0000, 1'b1, {16'h0000, KEY_STOP_2}, 1'b0}
   };

   watchdog_timer_registers uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_reg_select    (req_reg_select),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_reset_request (rsp_reset_request)
   );

   always #6 clock = ~clock;

   function automatic result_type next_wdt_result(item_type w);
      result_type          r;
      bit                  adv;
      logic [SS_WIDTH-1:0] ss;
      r   = '0;
      adv = 1'b0;
      case (w.command)
         CMD_READ: begin
            case (w.reg_select)
               SEL_CONTROL:   r.read_data = DATA_WIDTH'(m_ctrl);
               SEL_COUNTER:   r.read_data = DATA_WIDTH'(m_count);
               SEL_LOAD:      r.read_data = DATA_WIDTH'(m_load);
               SEL_TRIGGER:   r.read_data = m_trig;
               SEL_STARTSTOP: r.read_data = DATA_WIDTH'(m_ss);
               SEL_PENDING:   r.read_data = DATA_WIDTH'(m_pend);
               default:       r.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            case (w.reg_select)
               SEL_CONTROL: begin
                  m_ctrl = w.write_data[CTRL_WIDTH-1:0] & CTRL_WRITE_MASK;
                  m_pend[PEND_CONTROL] = 1'b1;
               end
               SEL_COUNTER: begin
                  m_count = w.write_data[CW-1:0];
                  m_pend[PEND_COUNTER] = 1'b1;
               end
               SEL_LOAD: begin
                  m_load = w.write_data[CW-1:0];
                  m_pend[PEND_LOAD] = 1'b1;
               end
               SEL_TRIGGER: begin
                  if (w.write_data != m_trig) begin
                     m_count = m_load;
                     m_ps    = '0;
                  end
                  m_trig = w.write_data;
                  m_pend[PEND_TRIGGER] = 1'b1;
               end
               SEL_STARTSTOP: begin
                  ss = w.write_data[SS_WIDTH-1:0];
                  if (m_ss == KEY_START_1 && ss == KEY_START_2)
                     m_run = 1'b1;
                  else if (m_ss == KEY_STOP_1 && ss == KEY_STOP_2)
                     m_run = 1'b0;
                  m_ss = ss;
                  m_pend[PEND_STARTSTOP] = 1'b1;
               end
               default: ;
            endcase
         end
         CMD_TICK: begin
            m_pend = '0;
            if (m_run) begin
               if (m_ctrl[CTRL_PRE_BIT]) begin
                  m_ps = m_ps + 1'b1;
                  if (int'(m_ps) >= (1 << m_ctrl[CTRL_PTV_LSB +: PTV_WIDTH])) begin
                     m_ps = '0;
                     adv  = 1'b1;
                  end
               end else begin
                  m_ps = '0;
                  adv  = 1'b1;
               end
               if (adv) begin
                  if (m_count == {CW{1'b1}}) begin
                     m_count = m_load;
                     r.reset_request = 1'b1;
                  end else begin
                     m_count = m_count + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic push_word(logic [CMD_WIDTH-1:0] c, logic [SEL_WIDTH-1:0] s,
                            logic [DATA_WIDTH-1:0] d);
      item_type w;
      w.command    = c;
      w.reg_select = s;
      w.write_data = d;
      stim.push_back(w);
      stim_typed.push_back(1'b0);
      stim_rsp.push_back('0);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_word(CMD_TICK, SEL_CONTROL, $urandom());
   endtask

   function automatic logic [DATA_WIDTH-1:0] upper_noise(logic [SS_WIDTH-1:0] key);
      return {16'($urandom_range(0, 65535)), key};
   endfunction

   task automatic build_random_stim();
      int                    n_end;
      int                    pick;
      logic [DATA_WIDTH-1:0] d;
      n_end = stim.size() + N_RANDOM;
      while (stim.size() < n_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            push_ticks($urandom_range(1, 6));
         end else if (pick < 42) begin
            push_word(CMD_READ, 3'($urandom_range(0, 7)), $urandom());
         end else if (pick < 50) begin
            push_word(CMD_WRITE, SEL_STARTSTOP, upper_noise(KEY_START_1));
            push_word(CMD_WRITE, SEL_STARTSTOP, upper_noise(KEY_START_2));
         end else if (pick < 55) begin
            push_word(CMD_WRITE, SEL_STARTSTOP, upper_noise(KEY_STOP_1));
            push_word(CMD_WRITE, SEL_STARTSTOP, upper_noise(KEY_STOP_2));
         end else if (pick < 60) begin
            // broken key pair: first half, then a second half that may or may not complete it
            push_word(CMD_WRITE, SEL_STARTSTOP,
                      upper_noise($urandom_range(0, 1) ? KEY_START_1 : KEY_STOP_1));
            case ($urandom_range(0, 2))
               0:       d = upper_noise(KEY_STOP_2);
               1:       d = upper_noise(KEY_START_2);
               default: d = $urandom();
            endcase
            push_word(CMD_WRITE, SEL_STARTSTOP, d);
         end else if (pick < 68) begin
            // small value set so equal triggers happen often
            case ($urandom_range(0, 2))
               0:       d = '0;
               1:       d = 32'h0000_1234;
               default: d = $urandom();
            endcase
            push_word(CMD_WRITE, SEL_TRIGGER, d);
         end else if (pick < 75) begin
            d = $urandom();
            if ($urandom_range(0, 1))
               d[4:3] = 2'b00;
            push_word(CMD_WRITE, SEL_CONTROL, d);
         end else if (pick < 82) begin
            push_word(CMD_WRITE, SEL_COUNTER, 32'hFFFF_FFFF - $urandom_range(0, 3));
            push_ticks($urandom_range(1, 5));
            push_word(CMD_READ, SEL_COUNTER, $urandom());
         end else if (pick < 87) begin
            d = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 2);
            push_word(CMD_WRITE, SEL_LOAD, d);
         end else if (pick < 93) begin
            push_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom());
         end else begin
            push_word(CMD_WRITE, 3'($urandom_range(0, 4)), $urandom());
            push_word(CMD_READ, SEL_PENDING, $urandom());
         end
      end
   endtask

   // sender
   initial begin
      item_type   w;
      result_type p;
      bit         took;
      bit         go;
      int         sent;
      int         n_total;
      int         pause_at;
      int         burst_left;
      int         gap_left;

      m_ctrl  = '0;
      m_count = '0;
      m_load  = '0;
      m_trig  = '0;
      m_ss    = '0;
      m_run   = 1'b0;
      m_ps    = '0;
      m_pend  = '0;
      for (int i = 0; i < N_DIR; i++) begin
         w.command    = dir_tab[i].cmd;
         w.reg_select = dir_tab[i].sel;
         w.write_data = dir_tab[i].data;
         stim.push_back(w);
         stim_typed.push_back(dir_tab[i].typed);
         p.read_data     = dir_tab[i].rd;
         p.reset_request = dir_tab[i].rr;
         stim_rsp.push_back(p);
      end
      build_random_stim();
      n_total    = stim.size();
      pause_at   = n_total / 3;
      sent       = 0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(posedge clock);
         took = req_valid && !req_stall;
         if (took) begin
            w.command    = req_command;
            w.reg_select = req_reg_select;
            w.write_data = req_write_data;
            p = next_wdt_result(w);
            rsp_due_q.push_back(stim_typed[sent] ? stim_rsp[sent] : p);
            sent++;
         end
         go = 1'b0;
         if (sent == n_total) begin
            go = 1'b0;
         end else if (req_valid && !took) begin
            go = 1'b1;
         end else if (sent == pause_at && rsp_due_q.size() != 0) begin
            // drain the block once before going on
            go = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else begin
            go = 1'b1;
            req_command    <= stim[sent].command;
            req_reg_select <= stim[sent].reg_select;
            req_write_data <= stim[sent].write_data;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end
         end
         req_valid <= go;
         if (sent == n_total)
            break;
      end

      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (n_fail == 0)
         $display("watchdog_timer_registers_tb OK");
      else
         $display("watchdog_timer_registers_tb NOT OK");
      $finish;
   end

   // receiver: check each word, stall on its own pattern
   initial begin
      result_type e;
      int         hold_left;
      bit         hold_done;
      int         rx_phase;
      int         rx_period;
      int         rx_duty;
      bit         stall_next;

      hold_left = 0;
      hold_done = 1'b0;
      rx_phase  = 0;
      rx_period = 4;
      rx_duty   = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            n_rsp++;
            if (rsp_due_q.size() == 0) begin
               $error("unexpected word: read_data %h reset_request %b",
                      rsp_read_data, rsp_reset_request);
               n_fail++;
            end else begin
               e = rsp_due_q.pop_front();
               if (rsp_read_data !== e.read_data) begin
                  $error("read_data: expected %h, got %h", e.read_data, rsp_read_data);
                  n_fail++;
               end
               if (rsp_reset_request !== e.reset_request) begin
                  $error("reset_request: expected %b, got %b",
                         e.reset_request, rsp_reset_request);
                  n_fail++;
               end
            end
         end
         if (!hold_done && n_rsp >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = rx_phase < rx_duty;
            rx_phase++;
            if (rx_phase >= rx_period) begin
               rx_phase  = 0;
               rx_period = $urandom_range(1, 9);
               rx_duty   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, rx_period - 1);
            end
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles >= LIMIT) begin
         $display("watchdog_timer_registers_tb NOT OK");
         $finish;
      end
   end

endmodule
